>>> rtl/rssl_pkg.sv
// Shared types, codes and frame constants for the ranging sensor serial link.
`default_nettype none
package rssl_pkg;

    // Input transaction kinds
    localparam logic [2:0] KIND_TRIGGER = 3'd0;
    localparam logic [2:0] KIND_READ    = 3'd1;
    localparam logic [2:0] KIND_SETADDR = 3'd2;
    localparam logic [2:0] KIND_RXBYTE  = 3'd3;
    localparam logic [2:0] KIND_ABORT   = 3'd4;

    // Result kinds
    localparam logic [1:0] OUT_TX      = 2'd0;
    localparam logic [1:0] OUT_DIST    = 2'd1;
    localparam logic [1:0] OUT_ADDRRES = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_CHECKSUM = 2'd1;
    localparam logic [1:0] ST_REJECTED = 2'd2;
    localparam logic [1:0] ST_ABORTED  = 2'd3;

    // Jobs handed from the protocol controller to the frame emitter
    localparam logic [1:0] JOB_TRIGGER = 2'd0;
    localparam logic [1:0] JOB_READ    = 2'd1;
    localparam logic [1:0] JOB_SETADDR = 2'd2;
    localparam logic [1:0] JOB_RESULT  = 2'd3;

    // Reset address of the sensor
    localparam logic [7:0] RESET_ADDR = 8'd17;

    // Frame bytes
    localparam logic [7:0] HDR0       = 8'h55;
    localparam logic [7:0] HDR1       = 8'hAA;
    localparam logic [7:0] CMD_ZERO   = 8'h00;
    localparam logic [7:0] CMD_TRIG   = 8'h01;
    localparam logic [7:0] CMD_READ   = 8'h02;
    localparam logic [7:0] SA_BYTE2   = 8'hAB;
    localparam logic [7:0] SA_BYTE3   = 8'h01;
    localparam logic [7:0] SA_BYTE4   = 8'h55;
    localparam logic [7:0] ACK_OK     = 8'h01;
    localparam logic [15:0] DIST_NONE = 16'hFFFF;

    // Sum of the fixed bytes of each frame, modulo 256
    localparam logic [7:0] SUM_TRIG = 8'((32'h55 + 32'hAA + 32'h00 + 32'h01) % 256);
    localparam logic [7:0] SUM_READ = 8'((32'h55 + 32'hAA + 32'h00 + 32'h02) % 256);
    localparam logic [7:0] SUM_SA   = 8'((32'h55 + 32'hAA + 32'hAB + 32'h01 + 32'h55) % 256);

    // Protocol phases
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_DIST = 2'd1;
    localparam logic [1:0] PH_ADDR = 2'd2;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] new_address;
        logic [7:0] rx_byte;
    } t_in;

    typedef struct packed {
        logic [1:0]  out_kind;
        logic [7:0]  tx_byte;
        logic        last;
        logic [1:0]  status;
        logic [15:0] distance;
        logic        out_of_range;
    } t_out;

    typedef struct packed {
        logic [1:0]  job_kind;
        logic [7:0]  addr;
        logic [1:0]  out_kind;
        logic [1:0]  status;
        logic [15:0] distance;
        logic        out_of_range;
    } t_job;

endpackage
`default_nettype wire

>>> rtl/rssl_ctrl.sv
// Protocol controller: decodes each transaction, tracks the reply and issues jobs.
`default_nettype none
module rssl_ctrl (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_accept,
    input  rssl_pkg::t_in     i_data,
    output logic              o_job_valid,
    output rssl_pkg::t_job    o_job
);
    import rssl_pkg::*;

    logic [7:0]  r_device_address, n_device_address;
    logic [1:0]  r_phase, n_phase;
    logic [3:0]  r_reply_count, n_reply_count;
    logic [7:0]  r_reply_sum, n_reply_sum;
    logic [15:0] r_distance_capture, n_distance_capture;
    logic [7:0]  r_ack_byte, n_ack_byte;
    logic [7:0]  r_pending_address, n_pending_address;

    // Decode one transaction against the current protocol state
    always_comb begin
        n_device_address   = r_device_address;
        n_phase            = r_phase;
        n_reply_count      = r_reply_count;
        n_reply_sum        = r_reply_sum;
        n_distance_capture = r_distance_capture;
        n_ack_byte         = r_ack_byte;
        n_pending_address  = r_pending_address;
        o_job_valid        = 1'b0;
        o_job              = '0;
        o_job.addr         = r_device_address;
        case (i_data.kind)
            KIND_TRIGGER, KIND_READ, KIND_SETADDR: begin
                if (r_phase == PH_IDLE) begin
                    o_job_valid = i_accept;
                    if (i_data.kind == KIND_TRIGGER) begin
                        o_job.job_kind = JOB_TRIGGER;
                    end else if (i_data.kind == KIND_READ) begin
                        o_job.job_kind = JOB_READ;
                        n_phase        = PH_DIST;
                        n_reply_count  = '0;
                        n_reply_sum    = '0;
                    end else begin
                        o_job.job_kind    = JOB_SETADDR;
                        o_job.addr        = i_data.new_address;
                        n_pending_address = i_data.new_address;
                        n_phase           = PH_ADDR;
                        n_reply_count     = '0;
                        n_reply_sum       = '0;
                    end
                end
            end
            KIND_ABORT: begin
                if (r_phase == PH_DIST || r_phase == PH_ADDR) begin
                    o_job_valid    = i_accept;
                    o_job.job_kind = JOB_RESULT;
                    o_job.out_kind = (r_phase == PH_DIST) ? OUT_DIST : OUT_ADDRRES;
                    o_job.status   = ST_ABORTED;
                    n_reply_count  = '0;
                    n_reply_sum    = '0;
                end
                n_phase = PH_IDLE;
            end
            KIND_RXBYTE: begin
                if (r_phase == PH_DIST) begin
                    if (r_reply_count < 4'd7) begin
                        // Collect reply bytes, capturing the distance
                        if (r_reply_count == 4'd5) begin
                            n_distance_capture[15:8] = i_data.rx_byte;
                        end else if (r_reply_count == 4'd6) begin
                            n_distance_capture[7:0] = i_data.rx_byte;
                        end
                        n_reply_sum   = r_reply_sum + i_data.rx_byte;
                        n_reply_count = r_reply_count + 4'd1;
                    end else begin
                        o_job_valid    = i_accept;
                        o_job.job_kind = JOB_RESULT;
                        o_job.out_kind = OUT_DIST;
                        if (i_data.rx_byte != r_reply_sum) begin
                            o_job.status = ST_CHECKSUM;
                        end else begin
                            o_job.status       = ST_OK;
                            o_job.distance     = r_distance_capture;
                            o_job.out_of_range = (r_distance_capture == DIST_NONE);
                        end
                        n_phase       = PH_IDLE;
                        n_reply_count = '0;
                        n_reply_sum   = '0;
                    end
                end else if (r_phase == PH_ADDR) begin
                    if (r_reply_count < 4'd6) begin
                        if (r_reply_count == 4'd5) begin
                            n_ack_byte = i_data.rx_byte;
                        end
                        n_reply_sum   = r_reply_sum + i_data.rx_byte;
                        n_reply_count = r_reply_count + 4'd1;
                    end else begin
                        o_job_valid    = i_accept;
                        o_job.job_kind = JOB_RESULT;
                        o_job.out_kind = OUT_ADDRRES;
                        if (i_data.rx_byte != r_reply_sum) begin
                            o_job.status = ST_CHECKSUM;
                        end else if (r_ack_byte == ACK_OK) begin
                            o_job.status     = ST_OK;
                            n_device_address = r_pending_address;
                        end else begin
                            o_job.status = ST_REJECTED;
                        end
                        n_phase       = PH_IDLE;
                        n_reply_count = '0;
                        n_reply_sum   = '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Commit state on an accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_address   <= RESET_ADDR;
            r_phase            <= PH_IDLE;
            r_reply_count      <= '0;
            r_reply_sum        <= '0;
            r_distance_capture <= '0;
            r_ack_byte         <= '0;
            r_pending_address  <= '0;
        end else if (i_accept) begin
            r_device_address   <= n_device_address;
            r_phase            <= n_phase;
            r_reply_count      <= n_reply_count;
            r_reply_sum        <= n_reply_sum;
            r_distance_capture <= n_distance_capture;
            r_ack_byte         <= n_ack_byte;
            r_pending_address  <= n_pending_address;
        end
    end

endmodule
`default_nettype wire

>>> rtl/rssl_emit.sv
// Frame emitter: expands a job into result transactions, one per cycle unless stalled, via an output register.
`default_nettype none
module rssl_emit (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_job_valid,
    input  rssl_pkg::t_job    i_job,
    output logic              o_job_ready,
    output logic              o_valid,
    input  wire logic         i_ready,
    output rssl_pkg::t_out    o_data
);
    import rssl_pkg::*;

    logic        r_busy;
    t_job        r_job;
    logic [3:0]  r_idx;
    logic        r_out_valid;
    t_out        r_out;

    t_out        n_out;
    logic        out_free;
    logic        advance;
    logic        job_done;
    logic [2:0]  pos;
    logic        second;

    // Byte position within the current frame
    always_comb begin
        second = (r_job.job_kind == JOB_READ) && (r_idx >= 4'd6);
        pos    = second ? 3'(r_idx - 4'd6) : r_idx[2:0];
    end

    // Build the current result
    always_comb begin
        n_out          = '0;
        n_out.out_kind = OUT_TX;
        case (r_job.job_kind)
            JOB_TRIGGER, JOB_READ: begin
                case (pos)
                    3'd0:    n_out.tx_byte = HDR0;
                    3'd1:    n_out.tx_byte = HDR1;
                    3'd2:    n_out.tx_byte = r_job.addr;
                    3'd3:    n_out.tx_byte = CMD_ZERO;
                    3'd4:    n_out.tx_byte = second ? CMD_READ : CMD_TRIG;
                    default: n_out.tx_byte = r_job.addr + (second ? SUM_READ : SUM_TRIG);
                endcase
                n_out.last = (r_job.job_kind == JOB_TRIGGER) ? (r_idx == 4'd5)
                                                             : (r_idx == 4'd11);
            end
            JOB_SETADDR: begin
                case (pos)
                    3'd0:    n_out.tx_byte = HDR0;
                    3'd1:    n_out.tx_byte = HDR1;
                    3'd2:    n_out.tx_byte = SA_BYTE2;
                    3'd3:    n_out.tx_byte = SA_BYTE3;
                    3'd4:    n_out.tx_byte = SA_BYTE4;
                    3'd5:    n_out.tx_byte = r_job.addr;
                    default: n_out.tx_byte = r_job.addr + SUM_SA;
                endcase
                n_out.last = (r_idx == 4'd6);
            end
            default: begin
                n_out.out_kind     = r_job.out_kind;
                n_out.status       = r_job.status;
                n_out.distance     = r_job.distance;
                n_out.out_of_range = r_job.out_of_range;
                n_out.last         = 1'b1;
            end
        endcase
    end

    assign out_free    = !r_out_valid || i_ready;
    assign advance     = r_busy && out_free;
    assign job_done    = advance && n_out.last;
    assign o_job_ready = !r_busy || job_done;

    // Step through the job
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (i_job_valid && o_job_ready) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (job_done) begin
            r_busy <= 1'b0;
        end else if (advance) begin
            r_idx <= r_idx + 4'd1;
        end
    end

    // Load a new job
    always_ff @(posedge i_clk) begin
        if (i_job_valid && o_job_ready) begin
            r_job <= i_job;
        end
    end

    // Hold or refill the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule
`default_nettype wire

>>> rtl/ranging_sensor_serial_link.sv
// Top level of the ranging sensor serial link host.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------
//  request | in        | i_valid / o_ready  | i_data (t_in)
//  result  | out       | o_valid / i_ready  | o_data (t_out)
//
// One result leaves per cycle unless stalled: a read request gives 12, a set-address
// request 7, a trigger 6, a reply or abort result 1; the frame emitter's byte counter
// sets these. Transactions with no result are taken one per cycle when idle.
// The next request is taken in the cycle the current job hands over its last result.
// Synchronous active-low reset restores the default address and the idle phase.
// A stalled result holds in the output register while the next one is prepared.
`default_nettype none
module ranging_sensor_serial_link (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_ready,
    input  rssl_pkg::t_in     i_data,
    output logic              o_valid,
    input  wire logic         i_ready,
    output rssl_pkg::t_out    o_data
);
    import rssl_pkg::*;

    logic accept;
    logic job_valid;
    t_job job;

    assign accept = i_valid && o_ready;

    // Decode and track protocol state
    rssl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data      (i_data),
        .o_job_valid (job_valid),
        .o_job       (job)
    );

    // Expand jobs into result transactions
    rssl_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_job_ready (o_ready),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data)
    );

endmodule
`default_nettype wire
